// ----- src/fsa_pkg.sv -----
// Package with the shared constants, types and helper functions of the slot allocator.
package fsa_pkg;

    localparam int SLOTS        = 256;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int LINK_W       = SLOT_W + 1;
    localparam int HANDLE_W     = 8;
    localparam int LEN_W        = 16;
    localparam int LIMIT_W      = 8;
    localparam int STATUS_W     = 2;
    localparam int SLOT_FIELD_W = 8;
    localparam int WORD_W       = LINK_W + 1;

    localparam logic [LINK_W-1:0]   NULL_LINK   = LINK_W'(SLOTS);
    localparam logic [LINK_W-1:0]   LAST_SLOT   = LINK_W'(SLOTS - 1);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(12);

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd2;

    localparam logic RD_FREE_HEAD = 1'b0;
    localparam logic RD_CUR       = 1'b1;

    typedef struct packed {
        logic              ext;
        logic [LINK_W-1:0] link;
    } word_t;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic rd_sel;
        logic alloc_commit;
        logic walk_advance;
        logic unlink;
        logic free_commit;
        logic res_empty;
        logic res_miss;
    } cmd_t;

    typedef struct packed {
        logic free_empty;
        logic cur_null;
        logic cur_hit;
        logic out_free;
    } sts_t;

    function automatic logic [SLOT_FIELD_W-1:0] to_slot_field(input logic [LINK_W-1:0] v);
        logic [LINK_W+SLOT_FIELD_W-1:0] t;
        t = {{SLOT_FIELD_W{1'b0}}, v};
        return t[SLOT_FIELD_W-1:0];
    endfunction

    function automatic word_t reset_word(input logic [SLOT_W-1:0] addr);
        word_t w;
        w.ext = 1'b0;
        if ({1'b0, addr} == LAST_SLOT)
        begin
            w.link = NULL_LINK;
        end
        else
        begin
            w.link = {1'b0, addr} + LINK_W'(1);
        end
        return w;
    endfunction

endpackage

// ----- src/fsa_if.sv -----
// Request and result channel interfaces of the slot allocator.
interface fsa_req_if
    import fsa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [LEN_W-1:0]    length;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, output req_type, output length, output handle, input ready);
    modport sink   (input valid, input req_type, input length, input handle, output ready);
endinterface

interface fsa_rsp_if
    import fsa_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    local_storage;
    logic                    release_external;

    modport source (output valid, output status, output slot, output local_storage,
                    output release_external, input ready);
    modport sink   (input valid, input status, input slot, input local_storage,
                    input release_external, output ready);
endinterface

// ----- src/fsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/fsa_ctrl.sv -----
// Controller state machine that sequences allocate and free requests.
module fsa_ctrl
    import fsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_req_type,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ALLOC_RD  = 3'd1;
    localparam logic [2:0] S_ALLOC_WR  = 3'd2;
    localparam logic [2:0] S_WALK_RD   = 3'd3;
    localparam logic [2:0] S_WALK_DATA = 3'd4;
    localparam logic [2:0] S_FREE_WR   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = in_req_type ? S_WALK_RD : S_ALLOC_RD;
                end
            end
            S_ALLOC_RD:
            begin
                if (sts.free_empty)
                begin
                    if (sts.out_free)
                    begin
                        cmd.res_empty = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_FREE_HEAD;
                    state_next = S_ALLOC_WR;
                end
            end
            S_ALLOC_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_WALK_RD:
            begin
                if (sts.cur_null)
                begin
                    if (sts.out_free)
                    begin
                        cmd.res_miss = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    state_next = S_WALK_DATA;
                end
            end
            S_WALK_DATA:
            begin
                if (sts.cur_hit)
                begin
                    cmd.unlink = 1'b1;
                    state_next = S_FREE_WR;
                end
                else
                begin
                    cmd.walk_advance = 1'b1;
                    state_next       = S_WALK_RD;
                end
            end
            S_FREE_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.free_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_result_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alloc_commit || cmd.free_commit || cmd.res_empty || cmd.res_miss)
        |-> sts.out_free)
        else $error("result issued while the output register is occupied");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg != S_IDLE)
        else $error("controller stayed idle after taking a request");

endmodule

// ----- src/fsa_datapath.sv -----
// Datapath with list heads, link memory, walk registers and the result register.
module fsa_datapath
    import fsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [LEN_W-1:0]    in_length,
    input  logic [HANDLE_W-1:0] in_handle,
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_wdata,
    fsa_rsp_if.source           rsp
);

    logic [LIMIT_W-1:0]      small_limit_reg;
    logic [LINK_W-1:0]       free_head_reg;
    logic [LINK_W-1:0]       inuse_head_reg;
    logic [LINK_W-1:0]       cur_reg;
    logic [LINK_W-1:0]       prev_reg;
    logic                    prev_ext_reg;
    logic [LEN_W-1:0]        length_reg;
    logic [HANDLE_W-1:0]     handle_reg;
    logic [SLOTS-1:0]        valid_reg;
    logic [SLOT_W-1:0]       rd_addr_reg;
    logic                    rd_valid_reg;
    logic                    rsp_valid_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [SLOT_FIELD_W-1:0] slot_reg;
    logic                    local_reg;
    logic                    release_reg;

    logic [SLOT_W-1:0]   rd_addr;
    logic [WORD_W-1:0]   ram_q;
    word_t               word;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    word_t               wr_word;
    logic                is_local;
    logic                prev_null;
    logic                result_load;

    assign rd_addr   = (cmd.rd_sel == RD_CUR) ? cur_reg[SLOT_W-1:0] : free_head_reg[SLOT_W-1:0];
    assign word      = rd_valid_reg ? word_t'(ram_q) : reset_word(rd_addr_reg);
    assign is_local  = length_reg < LEN_W'(small_limit_reg);
    assign prev_null = prev_reg >= NULL_LINK;

    assign sts.free_empty = free_head_reg >= NULL_LINK;
    assign sts.cur_null   = cur_reg >= NULL_LINK;
    assign sts.cur_hit    = (cur_reg < NULL_LINK) &&
        ({{HANDLE_W{1'b0}}, cur_reg} == {{LINK_W{1'b0}}, handle_reg});
    assign sts.out_free   = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = free_head_reg[SLOT_W-1:0];
        wr_word = '0;
        if (cmd.alloc_commit)
        begin
            wr_en        = 1'b1;
            wr_addr      = free_head_reg[SLOT_W-1:0];
            wr_word.ext  = !is_local;
            wr_word.link = inuse_head_reg;
        end
        else if (cmd.unlink && !prev_null)
        begin
            wr_en        = 1'b1;
            wr_addr      = prev_reg[SLOT_W-1:0];
            wr_word.ext  = prev_ext_reg;
            wr_word.link = word.link;
        end
        else if (cmd.free_commit)
        begin
            wr_en        = 1'b1;
            wr_addr      = cur_reg[SLOT_W-1:0];
            wr_word.ext  = 1'b0;
            wr_word.link = free_head_reg;
        end
    end

    fsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_limit_reg <= LIMIT_RESET;
            free_head_reg   <= '0;
            inuse_head_reg  <= NULL_LINK;
            valid_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                small_limit_reg <= cfg_wdata;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.alloc_commit)
            begin
                free_head_reg  <= word.link;
                inuse_head_reg <= free_head_reg;
            end
            if (cmd.unlink && prev_null)
            begin
                inuse_head_reg <= word.link;
            end
            if (cmd.free_commit)
            begin
                free_head_reg <= cur_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            length_reg <= in_length;
            handle_reg <= in_handle;
            cur_reg    <= inuse_head_reg;
            prev_reg   <= NULL_LINK;
        end
        if (cmd.walk_advance)
        begin
            prev_reg     <= cur_reg;
            prev_ext_reg <= word.ext;
            cur_reg      <= word.link;
        end
        if (cmd.rd_en)
        begin
            rd_addr_reg  <= rd_addr;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign result_load = cmd.alloc_commit || cmd.free_commit || cmd.res_empty || cmd.res_miss;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc_commit)
        begin
            status_reg  <= STATUS_OK;
            slot_reg    <= to_slot_field(free_head_reg);
            local_reg   <= is_local;
            release_reg <= 1'b0;
        end
        else if (cmd.free_commit)
        begin
            status_reg  <= STATUS_OK;
            slot_reg    <= to_slot_field(cur_reg);
            local_reg   <= !word.ext;
            release_reg <= word.ext;
        end
        else if (cmd.res_empty)
        begin
            status_reg  <= STATUS_EMPTY;
            slot_reg    <= '0;
            local_reg   <= 1'b0;
            release_reg <= 1'b0;
        end
        else if (cmd.res_miss)
        begin
            status_reg  <= STATUS_MISS;
            slot_reg    <= handle_reg;
            local_reg   <= 1'b0;
            release_reg <= 1'b0;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.slot             = slot_reg;
    assign rsp.local_storage    = local_reg;
    assign rsp.release_external = release_reg;

    a_heads_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg != inuse_head_reg)
        else $error("free and in-use lists share a head slot");

    a_no_read_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && cmd.rd_en))
        else $error("link memory read and written in the same cycle");

    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alloc_commit || cmd.free_commit) |=> rsp_valid_reg && status_reg == STATUS_OK)
        else $error("completed request did not present a successful result");

endmodule

// ----- src/fixed_slot_string_allocator_top.sv -----
// Top level of the fixed-slot string allocator: controller, datapath and channel wiring.
//
// The allocator manages a pool of SLOTS linked slots. Each request is taken
// on its own and yields one result. An allocate request that finds a free
// slot does one read and one write of the link memory between acceptance
// and result. A free request walks the in-use list from its most recently
// allocated slot, with a link memory read and a compare for each visited
// slot, does the unlink in the compare step of the found slot and then
// returns the slot to the free list; a handle that is not in use walks the
// whole list. The controller returns to idle after each result. A new
// request is taken in the cycle after a result is loaded, while that result
// still waits in the output register. The small limit register is written
// through cfg_we and cfg_wdata while the block is idle; this is a rule for
// the user, which the block itself does not enforce.
module fixed_slot_string_allocator_top
    import fsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    fsa_req_if.sink            req,
    fsa_rsp_if.source          rsp
);

    cmd_t cmd;
    sts_t sts;

    fsa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_ready    (req.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    fsa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_length (req.length),
        .in_handle (req.handle),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp       (rsp)
    );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the fixed-slot string allocator, with its own pool model.
`timescale 1ns / 1ps

module testbench;
    import fsa_pkg::*;

    localparam logic     REQ_ALLOC   = 1'b0;
    localparam logic     REQ_FREE    = 1'b1;
    localparam int       HOLD_CYCLES = 400;
    localparam int       SETTLE      = 8;
    localparam int       DRAIN       = 40;
    localparam int       CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic                req_type;
        logic [LEN_W-1:0]    length;
        logic [HANDLE_W-1:0] handle;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    local_storage;
        logic                    release_external;
    } grant_t;

    class slot_pool_scoreboard;
        logic [LINK_W-1:0]  next_link [SLOTS];
        logic               ext_store [SLOTS];
        logic [LINK_W-1:0]  free_head;
        logic [LINK_W-1:0]  inuse_head;
        logic [LIMIT_W-1:0] small_limit;
        grant_t             grants_due [$];
        int                 errors;
        int                 empty_seen;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                next_link[i] = (i == SLOTS - 1) ? NULL_LINK : LINK_W'(i + 1);
                ext_store[i] = 1'b0;
            end
            free_head   = '0;
            inuse_head  = NULL_LINK;
            small_limit = LIMIT_RESET;
            errors      = 0;
            empty_seen  = 0;
        endfunction

        function void set_limit(input logic [LIMIT_W-1:0] value);
            small_limit = value;
        endfunction

        function int pending();
            return grants_due.size();
        endfunction

        function int in_use_count();
            logic [LINK_W-1:0] cur;
            int                n;
            cur = inuse_head;
            n   = 0;
            while (cur != NULL_LINK && n < SLOTS)
            begin
                cur = next_link[cur[SLOT_W-1:0]];
                n++;
            end
            return n;
        endfunction

        function logic [HANDLE_W-1:0] pick_live_slot();
            logic [LINK_W-1:0] cur;
            int                k;
            cur = inuse_head;
            k   = $urandom_range(0, in_use_count() - 1);
            while (k > 0)
            begin
                cur = next_link[cur[SLOT_W-1:0]];
                k--;
            end
            return HANDLE_W'(cur);
        endfunction

        function void note_request(input request_t r);
            grant_t            g;
            logic [LINK_W-1:0] prev;
            logic [LINK_W-1:0] cur;
            logic              ext;
            logic              is_local;
            int                steps;
            g = '0;
            if (r.req_type == REQ_ALLOC)
            begin
                if (free_head == NULL_LINK)
                begin
                    g.status = STATUS_EMPTY;
                    empty_seen++;
                end
                else
                begin
                    cur           = free_head;
                    is_local      = r.length < LEN_W'(small_limit);
                    ext_store[cur[SLOT_W-1:0]] = !is_local;
                    free_head     = next_link[cur[SLOT_W-1:0]];
                    next_link[cur[SLOT_W-1:0]] = inuse_head;
                    inuse_head    = cur;
                    g.status        = STATUS_OK;
                    g.slot          = SLOT_FIELD_W'(cur);
                    g.local_storage = is_local;
                end
            end
            else
            begin
                prev  = NULL_LINK;
                cur   = inuse_head;
                steps = 0;
                while (cur != NULL_LINK && steps < SLOTS && cur != LINK_W'(r.handle))
                begin
                    prev = cur;
                    cur  = next_link[cur[SLOT_W-1:0]];
                    steps++;
                end
                if (cur == NULL_LINK || cur != LINK_W'(r.handle))
                begin
                    g.status = STATUS_MISS;
                    g.slot   = SLOT_FIELD_W'(r.handle);
                end
                else
                begin
                    ext = ext_store[cur[SLOT_W-1:0]];
                    ext_store[cur[SLOT_W-1:0]] = 1'b0;
                    if (prev == NULL_LINK)
                        inuse_head = next_link[cur[SLOT_W-1:0]];
                    else
                        next_link[prev[SLOT_W-1:0]] = next_link[cur[SLOT_W-1:0]];
                    next_link[cur[SLOT_W-1:0]] = free_head;
                    free_head = cur;
                    g.status           = STATUS_OK;
                    g.slot             = SLOT_FIELD_W'(cur);
                    g.local_storage    = !ext;
                    g.release_external = ext;
                end
            end
            grants_due.push_back(g);
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input grant_t got);
            grant_t want;
            if (grants_due.size() == 0)
            begin
                $error("result with no request outstanding: status %0d slot %0d",
                       got.status, got.slot);
                errors++;
                return;
            end
            want = grants_due.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("slot", want.slot, got.slot);
            compare_field("local_storage", want.local_storage, got.local_storage);
            compare_field("release_external", want.release_external, got.release_external);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;
    logic               hold_request;
    int                 burst_left;
    int unsigned        cycle_count;
    slot_pool_scoreboard sb;

    fsa_req_if req_ch ();
    fsa_rsp_if rsp_ch ();

    fixed_slot_string_allocator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        grant_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status           = rsp_ch.status;
            got.slot             = rsp_ch.slot;
            got.local_storage    = rsp_ch.local_storage;
            got.release_external = rsp_ch.release_external;
            sb.check_result(got);
        end
    end

    // The receiver switches between stall patterns, and once holds off for a long stretch.
    initial
    begin : receiver
        int mode;
        int left;
        int phase;
        mode  = 0;
        left  = 0;
        phase = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 200);
            end
            left--;
            phase = (phase + 1) % 3;
            case (mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                2: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                default: rsp_ch.ready <= (phase == 0);
            endcase
        end
    end

    function automatic request_t make_request(input logic kind, input int unsigned len,
                                              input int unsigned hnd);
        request_t r;
        r.req_type = kind;
        r.length   = LEN_W'(len);
        r.handle   = HANDLE_W'(hnd);
        return r;
    endfunction

    function automatic request_t random_request(input int alloc_pct);
        request_t r;
        r.handle = HANDLE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: r.length = LEN_W'($urandom_range(0, 65535));
            1: r.length = LEN_W'(sb.small_limit) + LEN_W'($urandom_range(0, 2)) - LEN_W'(1);
            2: r.length = LEN_W'($urandom_range(0, 31));
            default: r.length = LEN_W'(1) << $urandom_range(0, LEN_W - 1);
        endcase
        if ($urandom_range(1, 100) <= alloc_pct)
        begin
            r.req_type = REQ_ALLOC;
        end
        else
        begin
            r.req_type = REQ_FREE;
            if (sb.in_use_count() > 0 && $urandom_range(0, 9) != 0)
                r.handle = sb.pick_live_slot();
        end
        return r;
    endfunction

    task automatic offer(input request_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r.req_type;
        req_ch.length   <= r.length;
        req_ch.handle   <= r.handle;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sb.note_request(r);
        burst_left--;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_small_limit(input logic [LIMIT_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limit(value);
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int count,
                             input int alloc_pct, input int empties, input logic hold);
        int n;
        int empties_start;
        write_small_limit(limit);
        if (hold)
            hold_request = 1'b1;
        empties_start = sb.empty_seen;
        n = 0;
        while (n < count && !(empties > 0 && sb.empty_seen - empties_start >= empties))
        begin
            offer(random_request(alloc_pct));
            n++;
        end
        req_ch.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        sb              = new();
        hold_request    = 1'b0;
        burst_left      = 0;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_ALLOC;
        req_ch.length   <= '0;
        req_ch.handle   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with the small limit at its reset value.
        offer(make_request(REQ_FREE,  0,     0));
        offer(make_request(REQ_ALLOC, 0,     0));
        offer(make_request(REQ_ALLOC, 11,    0));
        offer(make_request(REQ_ALLOC, 12,    0));
        offer(make_request(REQ_ALLOC, 65535, 0));
        offer(make_request(REQ_ALLOC, 13,    255));
        offer(make_request(REQ_FREE,  0,     255));
        offer(make_request(REQ_FREE,  0,     2));
        offer(make_request(REQ_FREE,  0,     2));
        offer(make_request(REQ_FREE,  0,     4));
        offer(make_request(REQ_FREE,  0,     0));
        offer(make_request(REQ_ALLOC, 5,     170));
        offer(make_request(REQ_FREE,  65535, 3));
        offer(make_request(REQ_FREE,  0,     1));
        offer(make_request(REQ_FREE,  0,     0));
        offer(make_request(REQ_ALLOC, 32768, 85));
        offer(make_request(REQ_FREE,  0,     128));
        req_ch.valid <= 1'b0;

        run_phase(8'd1,   150, 65, 0, 1'b1);
        run_phase(8'd255, 500, 90, 4, 1'b0);
        run_phase(8'd0,   220, 20, 0, 1'b0);
        run_phase(8'd128,  80, 50, 0, 1'b0);
        run_phase(LIMIT_W'($urandom_range(2, 254)), 80, 50, 0, 1'b0);

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
src/fsa_pkg.sv
src/fsa_if.sv
src/fsa_ram.sv
src/fsa_ctrl.sv
src/fsa_datapath.sv
src/fixed_slot_string_allocator_top.sv
dv/testbench.sv
